// File: rtl/core/spi_nor_flash_command_sequencer_core_macros.svh
// assertion macros for the spi nor flash command sequencer checker
// no dependencies; included by the checker file
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define SNFCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SNFCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/snfcs_pkg.sv
// shared types and constants of the spi nor flash command sequencer
// no dependencies; used by snfcs_step and the top level
package snfcs_pkg;

    localparam logic [7:0] CMD_WREN = 8'h06;
    localparam logic [7:0] CMD_RDSR = 8'h05;
    localparam logic [7:0] CMD_WRSR = 8'h01;
    localparam logic [7:0] CMD_FARD = 8'h0B;
    localparam logic [7:0] CMD_PROG = 8'h02;
    localparam logic [7:0] CMD_CERS = 8'hC7;
    localparam logic [7:0] BYTE_NULL = 8'h00;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_PROG  = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic MODE_REQ  = 1'b0;
    localparam logic MODE_SLOT = 1'b1;

    localparam int SR_WIP = 0;
    localparam int SR_WEL = 1;

    localparam logic [2:0] HDR_CMD    = 3'd0;
    localparam logic [2:0] HDR_ADDR_H = 3'd1;
    localparam logic [2:0] HDR_ADDR_M = 3'd2;
    localparam logic [2:0] HDR_ADDR_L = 3'd3;
    localparam logic [2:0] HDR_DUMMY  = 3'd4;

    localparam logic [8:0] PAGE_BYTES_RST = 9'd256;

    typedef enum logic [11:0] {
        PH_IDLE    = 12'b0000_0000_0001,
        PH_RD_HDR  = 12'b0000_0000_0010,
        PH_RD_DATA = 12'b0000_0000_0100,
        PH_WREN    = 12'b0000_0000_1000,
        PH_WEL_CMD = 12'b0000_0001_0000,
        PH_WEL_RD  = 12'b0000_0010_0000,
        PH_PG_HDR  = 12'b0000_0100_0000,
        PH_PG_DATA = 12'b0000_1000_0000,
        PH_WIP_CMD = 12'b0001_0000_0000,
        PH_WIP_RD  = 12'b0010_0000_0000,
        PH_WRSR    = 12'b0100_0000_0000,
        PH_ERASE   = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  kind;
        logic [23:0] addr;
        logic [23:0] remaining;
        logic [8:0]  chunk_left;
        logic [2:0]  hdr_idx;
        logic        erase_stage;
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [1:0]  op;
        logic [23:0] address;
        logic [23:0] length;
        logic [7:0]  rx_byte;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       shift_valid;
        logic       frame_last;
        logic       read_valid;
        logic [7:0] read_data;
        logic       data_taken;
        logic       done_res;
        logic       rejected;
    } t_result;

endpackage

// File: rtl/core/snfcs_step.sv
// next-state and result logic for one transaction of the sequencer
// depends on snfcs_pkg
module snfcs_step #(
    parameter int PAGE_MAX = 256
) (
    input  snfcs_pkg::t_state  i_state,
    input  snfcs_pkg::t_item   i_item,
    input  logic [8:0]         i_page_bytes,
    output snfcs_pkg::t_state  o_state,
    output snfcs_pkg::t_result o_result
);

    function automatic logic [8:0] chunk_of(input logic [23:0] rem, input logic [8:0] page);
        logic [8:0] p;
        p = page;
        if (p == 9'd0) p = 9'd1;
        if (32'(p) > 32'(PAGE_MAX)) p = 9'(PAGE_MAX);
        if ({15'd0, p} > rem) p = rem[8:0];
        return p;
    endfunction

    function automatic logic [7:0] addr_byte(input logic [2:0] idx, input logic [23:0] a);
        logic [7:0] b;
        if (idx == snfcs_pkg::HDR_ADDR_H) b = a[23:16];
        else if (idx == snfcs_pkg::HDR_ADDR_M) b = a[15:8];
        else b = a[7:0];
        return b;
    endfunction

    snfcs_pkg::t_state  ns;
    snfcs_pkg::t_result res;
    logic               run_emit;
    logic [7:0]         tx;
    logic               last;
    logic               taken;

    always_comb begin
        ns       = i_state;
        res      = '0;
        run_emit = 1'b0;
        if (i_item.mode == snfcs_pkg::MODE_REQ) begin
            if (i_state.phase != snfcs_pkg::PH_IDLE || i_item.op == snfcs_pkg::OP_NONE) begin
                res.rejected = 1'b1;
            end else begin
                ns.kind        = i_item.op;
                ns.addr        = i_item.address;
                ns.remaining   = i_item.length;
                ns.hdr_idx     = snfcs_pkg::HDR_CMD;
                ns.erase_stage = 1'b0;
                ns.chunk_left  = 9'd0;
                priority if (i_item.op == snfcs_pkg::OP_ERASE) begin
                    ns.phase = snfcs_pkg::PH_WREN;
                    run_emit = 1'b1;
                end else if (i_item.length == 24'd0) begin
                    res.done_res = 1'b1;
                end else if (i_item.op == snfcs_pkg::OP_READ) begin
                    ns.phase = snfcs_pkg::PH_RD_HDR;
                    run_emit = 1'b1;
                end else begin
                    ns.chunk_left = chunk_of(i_item.length, i_page_bytes);
                    ns.phase      = snfcs_pkg::PH_WREN;
                    run_emit      = 1'b1;
                end
            end
        end else if (i_state.phase == snfcs_pkg::PH_IDLE) begin
            res.rejected = 1'b1;
        end else begin
            unique case (i_state.phase)
                snfcs_pkg::PH_RD_HDR: begin
                    if (i_state.hdr_idx < snfcs_pkg::HDR_DUMMY) ns.hdr_idx = i_state.hdr_idx + 3'd1;
                    else ns.phase = snfcs_pkg::PH_RD_DATA;
                end
                snfcs_pkg::PH_RD_DATA: begin
                    res.read_valid = 1'b1;
                    res.read_data  = i_item.rx_byte;
                    ns.remaining   = i_state.remaining - 24'd1;
                    ns.addr        = i_state.addr + 24'd1;
                    if (ns.remaining == 24'd0) ns.phase = snfcs_pkg::PH_IDLE;
                end
                snfcs_pkg::PH_WREN:    ns.phase = snfcs_pkg::PH_WEL_CMD;
                snfcs_pkg::PH_WEL_CMD: ns.phase = snfcs_pkg::PH_WEL_RD;
                snfcs_pkg::PH_WEL_RD: begin
                    ns.hdr_idx = snfcs_pkg::HDR_CMD;
                    priority if (!i_item.rx_byte[snfcs_pkg::SR_WEL]) ns.phase = snfcs_pkg::PH_WEL_CMD;
                    else if (i_state.kind == snfcs_pkg::OP_PROG) ns.phase = snfcs_pkg::PH_PG_HDR;
                    else if (!i_state.erase_stage) ns.phase = snfcs_pkg::PH_WRSR;
                    else ns.phase = snfcs_pkg::PH_ERASE;
                end
                snfcs_pkg::PH_PG_HDR: begin
                    if (i_state.hdr_idx < snfcs_pkg::HDR_ADDR_L) ns.hdr_idx = i_state.hdr_idx + 3'd1;
                    else ns.phase = snfcs_pkg::PH_PG_DATA;
                end
                snfcs_pkg::PH_PG_DATA: begin
                    ns.addr       = i_state.addr + 24'd1;
                    ns.remaining  = i_state.remaining - 24'd1;
                    ns.chunk_left = i_state.chunk_left - 9'd1;
                    if (ns.chunk_left == 9'd0) ns.phase = snfcs_pkg::PH_WIP_CMD;
                end
                snfcs_pkg::PH_WIP_CMD: ns.phase = snfcs_pkg::PH_WIP_RD;
                snfcs_pkg::PH_WIP_RD: begin
                    priority if (i_item.rx_byte[snfcs_pkg::SR_WIP]) begin
                        ns.phase = snfcs_pkg::PH_WIP_CMD;
                    end else if (i_state.kind == snfcs_pkg::OP_PROG) begin
                        if (i_state.remaining == 24'd0) begin
                            ns.phase = snfcs_pkg::PH_IDLE;
                        end else begin
                            ns.chunk_left = chunk_of(i_state.remaining, i_page_bytes);
                            ns.phase      = snfcs_pkg::PH_WREN;
                        end
                    end else if (!i_state.erase_stage) begin
                        ns.erase_stage = 1'b1;
                        ns.phase       = snfcs_pkg::PH_WREN;
                    end else begin
                        ns.phase = snfcs_pkg::PH_IDLE;
                    end
                end
                snfcs_pkg::PH_WRSR: begin
                    if (i_state.hdr_idx == snfcs_pkg::HDR_CMD) ns.hdr_idx = snfcs_pkg::HDR_ADDR_H;
                    else ns.phase = snfcs_pkg::PH_WIP_CMD;
                end
                snfcs_pkg::PH_ERASE: ns.phase = snfcs_pkg::PH_WIP_CMD;
                default: ns.phase = snfcs_pkg::PH_IDLE;
            endcase
            if (ns.phase == snfcs_pkg::PH_IDLE) res.done_res = 1'b1;
            else run_emit = 1'b1;
        end

        // announce the byte of the new phase
        tx    = snfcs_pkg::BYTE_NULL;
        last  = 1'b0;
        taken = 1'b0;
        unique case (ns.phase)
            snfcs_pkg::PH_RD_HDR: begin
                if (ns.hdr_idx == snfcs_pkg::HDR_CMD) tx = snfcs_pkg::CMD_FARD;
                else if (ns.hdr_idx <= snfcs_pkg::HDR_ADDR_L) tx = addr_byte(ns.hdr_idx, ns.addr);
                else tx = snfcs_pkg::BYTE_NULL;
            end
            snfcs_pkg::PH_RD_DATA: last = (ns.remaining == 24'd1);
            snfcs_pkg::PH_WREN: begin
                tx   = snfcs_pkg::CMD_WREN;
                last = 1'b1;
            end
            snfcs_pkg::PH_WEL_CMD, snfcs_pkg::PH_WIP_CMD: tx = snfcs_pkg::CMD_RDSR;
            snfcs_pkg::PH_WEL_RD, snfcs_pkg::PH_WIP_RD: last = 1'b1;
            snfcs_pkg::PH_PG_HDR: begin
                if (ns.hdr_idx == snfcs_pkg::HDR_CMD) tx = snfcs_pkg::CMD_PROG;
                else tx = addr_byte(ns.hdr_idx, ns.addr);
            end
            snfcs_pkg::PH_PG_DATA: begin
                tx    = i_item.write_data;
                taken = 1'b1;
                last  = (ns.chunk_left == 9'd1);
            end
            snfcs_pkg::PH_WRSR: begin
                if (ns.hdr_idx == snfcs_pkg::HDR_CMD) tx = snfcs_pkg::CMD_WRSR;
                else last = 1'b1;
            end
            snfcs_pkg::PH_ERASE: begin
                tx   = snfcs_pkg::CMD_CERS;
                last = 1'b1;
            end
            default: tx = snfcs_pkg::BYTE_NULL;
        endcase
        if (run_emit) begin
            res.tx_byte     = tx;
            res.shift_valid = 1'b1;
            res.frame_last  = last;
            res.data_taken  = taken;
        end
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

// File: rtl/core/spi_nor_flash_command_sequencer_core.sv
// top level of the spi nor flash command sequencer: input register, state, result register
// depends on snfcs_pkg and snfcs_step
// One transaction on the input channel is either a request (fast read, program, chip erase)
// or the report of one finished bus byte slot; each gives exactly one result transaction with
// the next byte to shift, any read data and the done or rejected flags. The block sustains one
// transaction per clock while the result side is ready: an input register feeds the state
// update logic, and the state and the result register are written in the same cycle, so each
// result leaves through the result register together with the state update that it reflects.
// The output register lets a new transaction enter while a result still waits. The page_bytes
// register is written through the configuration channel, which is always ready; write it only
// while no request is in progress. page_bytes of zero acts as one, above PAGE_MAX as PAGE_MAX.
module spi_nor_flash_command_sequencer_core #(
    parameter int PAGE_MAX = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [1:0]  i_op,
    input  logic [23:0] i_address,
    input  logic [23:0] i_length,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_shift_valid,
    output logic        o_frame_last,
    output logic        o_read_valid,
    output logic [7:0]  o_read_data,
    output logic        o_data_taken,
    output logic        o_done_res,
    output logic        o_rejected,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    logic               r_in_valid;
    snfcs_pkg::t_item   r_item;
    logic               r_out_valid;
    snfcs_pkg::t_result r_result;
    snfcs_pkg::t_state  r_state;
    logic [8:0]         r_page_bytes;
    snfcs_pkg::t_state  n_state;
    snfcs_pkg::t_result n_result;
    logic               advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    snfcs_step #(
        .PAGE_MAX (PAGE_MAX)
    ) u_step (
        .i_state      (r_state),
        .i_item       (r_item),
        .i_page_bytes (r_page_bytes),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '{phase: snfcs_pkg::PH_IDLE, default: '0};
            r_page_bytes <= snfcs_pkg::PAGE_BYTES_RST;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) r_page_bytes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{mode: i_mode, op: i_op, address: i_address, length: i_length,
                        rx_byte: i_rx_byte, write_data: i_write_data};
        end
        if (advance) r_result <= n_result;
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_byte     = r_result.tx_byte;
    assign o_shift_valid = r_result.shift_valid;
    assign o_frame_last  = r_result.frame_last;
    assign o_read_valid  = r_result.read_valid;
    assign o_read_data   = r_result.read_data;
    assign o_data_taken  = r_result.data_taken;
    assign o_done_res    = r_result.done_res;
    assign o_rejected    = r_result.rejected;

endmodule

// File: rtl/core/snfcs_chk.sv
// port-level checker for the spi nor flash command sequencer, bound to the top level
// depends on spi_nor_flash_command_sequencer_core_macros.svh
`include "spi_nor_flash_command_sequencer_core_macros.svh"

module snfcs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_tx_byte,
    input logic        o_shift_valid,
    input logic        o_frame_last,
    input logic        o_read_valid,
    input logic [7:0]  o_read_data,
    input logic        o_data_taken,
    input logic        o_done_res,
    input logic        o_rejected
);

    // a stalled result holds
    `SNFCS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_tx_byte) && $stable(o_done_res) && $stable(o_rejected),
        "result changed while stalled")

    // each result shifts a byte, finishes, or rejects
    `SNFCS_ASSERT_NOW(a_one_kind, i_clk, i_rst_n, o_out_valid,
        $onehot({o_shift_valid, o_done_res, o_rejected}), "result kind not unique")

    // nothing on the bus without a shift
    `SNFCS_ASSERT_NOW(a_quiet_bus, i_clk, i_rst_n, o_out_valid && !o_shift_valid,
        o_tx_byte == 8'd0 && !o_frame_last && !o_data_taken, "bus fields set without shift")

    // read data is zero when not valid
    `SNFCS_ASSERT_NOW(a_read_clean, i_clk, i_rst_n, o_out_valid && !o_read_valid,
        o_read_data == 8'd0, "read data without read valid")

endmodule

bind spi_nor_flash_command_sequencer_core snfcs_chk u_snfcs_chk (.*);

// File: bench/spi_nor_flash_command_sequencer_core_test.sv
// self-checking bench for spi_nor_flash_command_sequencer_core: directed table, then random
// request and byte-slot traffic with a flash status responder and a built-in predictor
// depends on snfcs_pkg and the core rtl
module spi_nor_flash_command_sequencer_core_test;

    localparam int PAGE_LIMIT = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 135;

    typedef struct {
        snfcs_pkg::t_item   it;
        bit                 typed;
        snfcs_pkg::t_result res;
    } t_plan_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    snfcs_pkg::t_item in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;
    logic [7:0]  o_tx_byte;
    logic        o_shift_valid;
    logic        o_frame_last;
    logic        o_read_valid;
    logic [7:0]  o_read_data;
    logic        o_data_taken;
    logic        o_done_res;
    logic        o_rejected;

    // predicted sequencer state
    snfcs_pkg::t_phase ph;
    logic [1:0]  kind;
    logic [23:0] addr_ctr;
    logic [23:0] remaining;
    logic [8:0]  chunk;
    logic [2:0]  hdr;
    logic        erase2;
    logic [8:0]  page_reg;

    snfcs_pkg::t_result expected_results[$];
    t_plan_row   plan[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;

    spi_nor_flash_command_sequencer_core #(
        .PAGE_MAX(PAGE_LIMIT)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_mode       (in_item.mode),
        .i_op         (in_item.op),
        .i_address    (in_item.address),
        .i_length     (in_item.length),
        .i_rx_byte    (in_item.rx_byte),
        .i_write_data (in_item.write_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_tx_byte    (o_tx_byte),
        .o_shift_valid(o_shift_valid),
        .o_frame_last (o_frame_last),
        .o_read_valid (o_read_valid),
        .o_read_data  (o_read_data),
        .o_data_taken (o_data_taken),
        .o_done_res   (o_done_res),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned page_eff();
        int unsigned p;
        p = 32'(page_reg);
        if (p == 0) p = 1;
        if (p > PAGE_LIMIT) p = PAGE_LIMIT;
        return p;
    endfunction

    function automatic logic [8:0] chunk_len();
        int unsigned p;
        p = page_eff();
        if (32'(remaining) < p) p = 32'(remaining);
        return 9'(p);
    endfunction

    function automatic logic [7:0] addr_sel(logic [2:0] idx);
        if (idx == snfcs_pkg::HDR_ADDR_H) return addr_ctr[23:16];
        if (idx == snfcs_pkg::HDR_ADDR_M) return addr_ctr[15:8];
        return addr_ctr[7:0];
    endfunction

    function automatic void announce(input logic [7:0] wd, inout snfcs_pkg::t_result r);
        logic [7:0] tx;
        logic       last;
        logic       taken;
        tx = snfcs_pkg::BYTE_NULL;
        last = 1'b0;
        taken = 1'b0;
        case (ph)
            snfcs_pkg::PH_RD_HDR: begin
                if (hdr == snfcs_pkg::HDR_CMD) tx = snfcs_pkg::CMD_FARD;
                else if (hdr <= snfcs_pkg::HDR_ADDR_L) tx = addr_sel(hdr);
            end
            snfcs_pkg::PH_RD_DATA: last = (remaining == 24'd1);
            snfcs_pkg::PH_WREN: begin
                tx = snfcs_pkg::CMD_WREN;
                last = 1'b1;
            end
            snfcs_pkg::PH_WEL_CMD, snfcs_pkg::PH_WIP_CMD: tx = snfcs_pkg::CMD_RDSR;
            snfcs_pkg::PH_WEL_RD, snfcs_pkg::PH_WIP_RD: last = 1'b1;
            snfcs_pkg::PH_PG_HDR: begin
                tx = (hdr == snfcs_pkg::HDR_CMD) ? snfcs_pkg::CMD_PROG : addr_sel(hdr);
            end
            snfcs_pkg::PH_PG_DATA: begin
                tx = wd;
                taken = 1'b1;
                last = (chunk == 9'd1);
            end
            snfcs_pkg::PH_WRSR: begin
                if (hdr == snfcs_pkg::HDR_CMD) tx = snfcs_pkg::CMD_WRSR;
                else last = 1'b1;
            end
            snfcs_pkg::PH_ERASE: begin
                tx = snfcs_pkg::CMD_CERS;
                last = 1'b1;
            end
            default: return;
        endcase
        r.tx_byte = tx;
        r.shift_valid = 1'b1;
        r.frame_last = last;
        r.data_taken = taken;
    endfunction

    function automatic void reset_sequencer();
        ph = snfcs_pkg::PH_IDLE;
        kind = snfcs_pkg::OP_READ;
        addr_ctr = '0;
        remaining = '0;
        chunk = '0;
        hdr = snfcs_pkg::HDR_CMD;
        erase2 = 1'b0;
        page_reg = snfcs_pkg::PAGE_BYTES_RST;
    endfunction

    task automatic advance_sequencer(input snfcs_pkg::t_item it,
                                     output snfcs_pkg::t_result r);
        r = '0;
        if (it.mode == snfcs_pkg::MODE_REQ) begin
            if (ph != snfcs_pkg::PH_IDLE || it.op == snfcs_pkg::OP_NONE) begin
                r.rejected = 1'b1;
                return;
            end
            kind = it.op;
            addr_ctr = it.address;
            remaining = it.length;
            hdr = snfcs_pkg::HDR_CMD;
            erase2 = 1'b0;
            chunk = '0;
            if (it.op == snfcs_pkg::OP_ERASE) begin
                ph = snfcs_pkg::PH_WREN;
            end else if (it.length == '0) begin
                r.done_res = 1'b1;
                return;
            end else if (it.op == snfcs_pkg::OP_READ) begin
                ph = snfcs_pkg::PH_RD_HDR;
            end else begin
                chunk = chunk_len();
                ph = snfcs_pkg::PH_WREN;
            end
            announce(it.write_data, r);
            return;
        end
        if (ph == snfcs_pkg::PH_IDLE) begin
            r.rejected = 1'b1;
            return;
        end
        case (ph)
            snfcs_pkg::PH_RD_HDR: begin
                if (hdr < snfcs_pkg::HDR_DUMMY) hdr = hdr + 3'd1;
                else ph = snfcs_pkg::PH_RD_DATA;
            end
            snfcs_pkg::PH_RD_DATA: begin
                r.read_valid = 1'b1;
                r.read_data = it.rx_byte;
                remaining = remaining - 24'd1;
                addr_ctr = addr_ctr + 24'd1;
                if (remaining == '0) ph = snfcs_pkg::PH_IDLE;
            end
            snfcs_pkg::PH_WREN: ph = snfcs_pkg::PH_WEL_CMD;
            snfcs_pkg::PH_WEL_CMD: ph = snfcs_pkg::PH_WEL_RD;
            snfcs_pkg::PH_WEL_RD: begin
                hdr = snfcs_pkg::HDR_CMD;
                if (!it.rx_byte[snfcs_pkg::SR_WEL]) ph = snfcs_pkg::PH_WEL_CMD;
                else if (kind == snfcs_pkg::OP_PROG) ph = snfcs_pkg::PH_PG_HDR;
                else if (!erase2) ph = snfcs_pkg::PH_WRSR;
                else ph = snfcs_pkg::PH_ERASE;
            end
            snfcs_pkg::PH_PG_HDR: begin
                if (hdr < snfcs_pkg::HDR_ADDR_L) hdr = hdr + 3'd1;
                else ph = snfcs_pkg::PH_PG_DATA;
            end
            snfcs_pkg::PH_PG_DATA: begin
                addr_ctr = addr_ctr + 24'd1;
                remaining = remaining - 24'd1;
                chunk = chunk - 9'd1;
                if (chunk == '0) ph = snfcs_pkg::PH_WIP_CMD;
            end
            snfcs_pkg::PH_WIP_CMD: ph = snfcs_pkg::PH_WIP_RD;
            snfcs_pkg::PH_WIP_RD: begin
                if (it.rx_byte[snfcs_pkg::SR_WIP]) begin
                    ph = snfcs_pkg::PH_WIP_CMD;
                end else if (kind == snfcs_pkg::OP_PROG) begin
                    if (remaining == '0) begin
                        ph = snfcs_pkg::PH_IDLE;
                    end else begin
                        chunk = chunk_len();
                        ph = snfcs_pkg::PH_WREN;
                    end
                end else if (!erase2) begin
                    erase2 = 1'b1;
                    ph = snfcs_pkg::PH_WREN;
                end else begin
                    ph = snfcs_pkg::PH_IDLE;
                end
            end
            snfcs_pkg::PH_WRSR: begin
                if (hdr == snfcs_pkg::HDR_CMD) hdr = hdr + 3'd1;
                else ph = snfcs_pkg::PH_WIP_CMD;
            end
            snfcs_pkg::PH_ERASE: ph = snfcs_pkg::PH_WIP_CMD;
            default: ph = snfcs_pkg::PH_IDLE;
        endcase
        if (ph == snfcs_pkg::PH_IDLE) r.done_res = 1'b1;
        else announce(it.write_data, r);
    endtask

    // next transaction, shaped by what the sequencer currently waits for
    function automatic snfcs_pkg::t_item next_item();
        snfcs_pkg::t_item it;
        int unsigned      roll;
        int unsigned      cap;
        it.mode = snfcs_pkg::MODE_SLOT;
        it.op = 2'($urandom_range(0, 3));
        it.address = 24'($urandom);
        it.length = 24'($urandom);
        it.rx_byte = 8'($urandom);
        it.write_data = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (ph == snfcs_pkg::PH_IDLE) begin
            if (roll < 4) return it;
            it.mode = snfcs_pkg::MODE_REQ;
            if (roll < 8) begin
                it.op = snfcs_pkg::OP_NONE;
                return it;
            end
            roll = $urandom_range(0, 99);
            it.op = (roll < 40) ? snfcs_pkg::OP_READ :
                    (roll < 80) ? snfcs_pkg::OP_PROG : snfcs_pkg::OP_ERASE;
            if (it.op == snfcs_pkg::OP_ERASE) return it;
            if ($urandom_range(0, 9) == 0) it.address = 24'hFFFFFF - 24'($urandom_range(0, 3));
            cap = 2 * page_eff() + 2;
            if (cap > 300) cap = 300;
            roll = $urandom_range(0, 99);
            if (roll < 4) it.length = '0;
            else if (roll < 12) it.length = 24'($urandom_range(1, cap));
            else it.length = 24'($urandom_range(1, 12));
        end else begin
            if (roll < 5) begin
                it.mode = snfcs_pkg::MODE_REQ;
                return it;
            end
            if (ph == snfcs_pkg::PH_WEL_RD) begin
                it.rx_byte[snfcs_pkg::SR_WEL] = ($urandom_range(0, 3) != 0);
            end else if (ph == snfcs_pkg::PH_WIP_RD) begin
                it.rx_byte[snfcs_pkg::SR_WIP] = ($urandom_range(0, 2) == 0);
            end
        end
        return it;
    endfunction

    function automatic snfcs_pkg::t_item mk(logic mode, logic [1:0] op, logic [23:0] address,
                                            logic [23:0] length, logic [7:0] rx,
                                            logic [7:0] wd);
        snfcs_pkg::t_item it;
        it.mode = mode;
        it.op = op;
        it.address = address;
        it.length = length;
        it.rx_byte = rx;
        it.write_data = wd;
        return it;
    endfunction

    function automatic snfcs_pkg::t_result fixed_result(logic [7:0] tx, logic sv, logic last,
                                                        logic done, logic rej);
        snfcs_pkg::t_result r;
        r = '0;
        r.tx_byte = tx;
        r.shift_valid = sv;
        r.frame_last = last;
        r.done_res = done;
        r.rejected = rej;
        return r;
    endfunction

    function automatic void add_plain(snfcs_pkg::t_item it);
        plan.push_back('{it, 1'b0, snfcs_pkg::t_result'('0)});
    endfunction

    function automatic void add_typed(snfcs_pkg::t_item it, snfcs_pkg::t_result r);
        plan.push_back('{it, 1'b1, r});
    endfunction

    function automatic string describe(snfcs_pkg::t_result r);
        return $sformatf("tx %h sv %b last %b rv %b rd %h taken %b done %b rej %b",
                         r.tx_byte, r.shift_valid, r.frame_last, r.read_valid,
                         r.read_data, r.data_taken, r.done_res, r.rejected);
    endfunction

    task automatic send_item(input snfcs_pkg::t_item it, input bit typed,
                             input snfcs_pkg::t_result typed_res, output bit ignored);
        snfcs_pkg::t_result r;
        while (!calm && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        advance_sequencer(it, r);
        expected_results.push_back(typed ? typed_res : r);
        ignored = r.rejected;
        @(negedge clk);
    endtask

    task automatic write_page(logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        page_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge clk) begin : check_results
        snfcs_pkg::t_result got;
        snfcs_pkg::t_result want;
        if (rst_n && out_valid && out_ready) begin
            got = '{o_tx_byte, o_shift_valid, o_frame_last, o_read_valid, o_read_data,
                    o_data_taken, o_done_res, o_rejected};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %s", describe(got));
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %s", describe(want));
                        $display("          actual   %s", describe(got));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [8:0]       page_plan [8];
        snfcs_pkg::t_item it;
        bit               ignored;
        int unsigned      taken_items;

        page_plan = '{9'd0, 9'd1, 9'd511, 9'd256, 9'd2, 9'd255, 9'd3, 9'd128};
        page_plan[6] = 9'($urandom_range(3, 254));
        page_plan[7] = 9'($urandom_range(0, 511));
        reset_sequencer();

        add_typed(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_READ, '0, '0, 8'hFF, 8'hFF),
                  fixed_result(snfcs_pkg::BYTE_NULL, 1'b0, 1'b0, 1'b0, 1'b1));
        add_typed(mk(snfcs_pkg::MODE_REQ, snfcs_pkg::OP_NONE, 24'hFFFFFF, 24'hFFFFFF,
                     8'h00, 8'h00),
                  fixed_result(snfcs_pkg::BYTE_NULL, 1'b0, 1'b0, 1'b0, 1'b1));
        add_typed(mk(snfcs_pkg::MODE_REQ, snfcs_pkg::OP_READ, 24'h123456, '0, 8'h00, 8'h00),
                  fixed_result(snfcs_pkg::BYTE_NULL, 1'b0, 1'b0, 1'b1, 1'b0));
        add_typed(mk(snfcs_pkg::MODE_REQ, snfcs_pkg::OP_PROG, 24'hABCDEF, '0, 8'h00, 8'h00),
                  fixed_result(snfcs_pkg::BYTE_NULL, 1'b0, 1'b0, 1'b1, 1'b0));
        // fast read across the top of the address space
        add_typed(mk(snfcs_pkg::MODE_REQ, snfcs_pkg::OP_READ, 24'hFFFFFF, 24'd2, 8'h00, 8'h00),
                  fixed_result(snfcs_pkg::CMD_FARD, 1'b1, 1'b0, 1'b0, 1'b0));
        add_typed(mk(snfcs_pkg::MODE_REQ, snfcs_pkg::OP_ERASE, 24'h000000, 24'hFFFFFF,
                     8'hFF, 8'hFF),
                  fixed_result(snfcs_pkg::BYTE_NULL, 1'b0, 1'b0, 1'b0, 1'b1));
        for (int k = 0; k < 5; k++) begin
            add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_READ, '0, '0, 8'h5A, 8'h00));
        end
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_READ, '0, '0, 8'hFF, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_READ, '0, '0, 8'h00, 8'h00));
        // one byte program with a write-enable retry
        add_typed(mk(snfcs_pkg::MODE_REQ, snfcs_pkg::OP_PROG, 24'hFFFFFF, 24'd1, 8'h00, 8'h00),
                  fixed_result(snfcs_pkg::CMD_WREN, 1'b1, 1'b1, 1'b0, 1'b0));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'hFD, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h02, 8'h00));
        for (int k = 0; k < 3; k++) begin
            add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'h00));
        end
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'hFF));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'h00, 8'h00));
        add_plain(mk(snfcs_pkg::MODE_SLOT, snfcs_pkg::OP_PROG, '0, '0, 8'hFE, 8'h00));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k]) send_item(plan[k].it, plan[k].typed, plan[k].res, ignored);

        for (int p = 0; p < 8; p++) begin
            in_valid <= 1'b0;
            drain();
            @(negedge clk);
            write_page(page_plan[p]);
            calm = (p == 3);
            taken_items = 0;
            while (taken_items < ITEMS_PER_PHASE || ph != snfcs_pkg::PH_IDLE) begin
                it = next_item();
                send_item(it, 1'b0, snfcs_pkg::t_result'('0), ignored);
                if (!ignored) taken_items++;
            end
        end
        in_valid <= 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/snfcs_pkg.sv
rtl/core/snfcs_step.sv
rtl/core/spi_nor_flash_command_sequencer_core.sv
rtl/core/snfcs_chk.sv
bench/spi_nor_flash_command_sequencer_core_test.sv
